/* design/uhfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhfd_pkg
// Shared types, constants and helpers of the header/footer frame deframer.
// ----------------------------------------------------------------------------
package uhfd_pkg;

  localparam int unsigned LenW  = 7;  // holds a frame length up to 64
  localparam int unsigned AddrW = 6;  // store address, up to 64 entries

  localparam logic [39:0] HEADER_RESET = 40'h6A_736F_6E3A;  // "json:"
  localparam logic [15:0] FOOTER_RESET = 16'h0D0A;          // CR LF

  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_S = 8'h53;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_BRAKE    = 2'd1;
  localparam logic [1:0] KIND_THROTTLE = 2'd2;
  localparam logic [1:0] KIND_STEER    = 2'd3;

  // one queued job for the back end: a finished frame or an overflow drop
  typedef struct packed {
    logic            ovf;
    logic [1:0]      kind;
    logic [LenW-1:0] len;
  } desc_t;

  // store write port, front to back
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  function automatic logic [7:0] hdr_byte(input logic [39:0] pat, input logic [2:0] idx);
    logic [7:0] res;
    unique case (idx)
      3'd0:    res = pat[39:32];
      3'd1:    res = pat[31:24];
      3'd2:    res = pat[23:16];
      3'd3:    res = pat[15:8];
      3'd4:    res = pat[7:0];
      default: res = pat[39:32];
    endcase
    return res;
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] b);
    logic [1:0] res;
    unique case (b)
      CHAR_B:  res = KIND_BRAKE;
      CHAR_T:  res = KIND_THROTTLE;
      CHAR_S:  res = KIND_STEER;
      default: res = KIND_NONE;
    endcase
    return res;
  endfunction

endpackage

/* design/uhfd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhfd_fifo
// Two-entry job queue between the frame sync front and the drain back end.
// ----------------------------------------------------------------------------
module uhfd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uhfd_pkg::desc_t push_data_i,
  input  logic          pop_i,
  output uhfd_pkg::desc_t pop_data_o,
  output logic          not_empty_o,
  output logic          not_full_o
);
  import uhfd_pkg::*;

  desc_t      slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign not_empty_o = (cnt_q != 2'd0);
  assign not_full_o  = (cnt_q != 2'd2);
  assign pop_data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (not_full_o || pop_i))
    else $error("job queue overrun");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("job queue underrun");

endmodule

/* design/uhfd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhfd_front
// Header hunt and footer match on the received byte stream; writes body
// bytes to the frame store and queues a job per finished or dropped frame.
// ----------------------------------------------------------------------------
module uhfd_front #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned HEADER_LEN   = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [39:0]     header_i,
  input  logic [15:0]     footer_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            mem_busy_i,
  input  logic            q_not_full_i,
  output logic            q_push_o,
  output uhfd_pkg::desc_t q_data_o,
  output uhfd_pkg::wr_t   wr_o
);
  import uhfd_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_FOOT = 2'd2;

  logic [1:0]    phase_q, phase_d;
  logic [2:0]    match_q, match_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [1:0]    kind_q, kind_d;

  logic          in_body;
  logic          acc;
  logic [2:0]    hm;
  logic [2:0]    hm_next;
  logic [CW-1:0] n;
  logic [1:0]    kind_now;
  logic [7:0]    fbyte;

  assign in_body    = (phase_q == PH_BODY) || (phase_q == PH_FOOT);
  // body bytes overwrite the store, so they wait until the last frame drained
  assign in_ready_o = q_not_full_i && !(in_body && mem_busy_i);
  assign acc        = in_valid_i && in_ready_o;

  assign n        = fill_q + CW'(1);
  assign kind_now = (fill_q == '0) ? kind_of(in_byte_i) : kind_q;
  assign fbyte    = (match_q == 3'd1) ? footer_i[7:0] : footer_i[15:8];
  assign hm       = (match_q >= 3'(HEADER_LEN)) ? 3'd0 : match_q;

  always_comb begin
    phase_d   = phase_q;
    match_d   = match_q;
    fill_d    = fill_q;
    kind_d    = kind_q;
    q_push_o  = 1'b0;
    q_data_o  = '0;
    wr_o      = '0;
    hm_next   = 3'd0;
    if (acc) begin
      if (in_body) begin
        wr_o.en   = 1'b1;
        wr_o.addr = AddrW'(fill_q);
        wr_o.data = in_byte_i;
        kind_d    = kind_now;
        fill_d    = n;
        if (n == CW'(BUFFER_DEPTH)) begin
          // store full: drop the frame, even if this byte ends the footer
          q_push_o     = 1'b1;
          q_data_o.ovf = 1'b1;
          phase_d      = PH_HUNT;
          match_d      = 3'd0;
          fill_d       = '0;
        end else if (in_byte_i == fbyte) begin
          if (match_q == 3'd1) begin
            q_push_o      = 1'b1;
            q_data_o.kind = kind_now;
            q_data_o.len  = LenW'(n);
            phase_d       = PH_HUNT;
            match_d       = 3'd0;
            fill_d        = '0;
          end else begin
            phase_d = PH_FOOT;
            match_d = 3'd1;
          end
        end else if (phase_q == PH_FOOT && in_byte_i == footer_i[15:8]) begin
          match_d = 3'd1;
        end else begin
          phase_d = PH_BODY;
          match_d = 3'd0;
        end
      end else begin
        if (in_byte_i == hdr_byte(header_i, hm)) begin
          hm_next = hm + 3'd1;
        end else if (in_byte_i == hdr_byte(header_i, 3'd0)) begin
          hm_next = 3'd1;
        end
        phase_d = PH_HUNT;
        match_d = hm_next;
        if (hm_next >= 3'(HEADER_LEN)) begin
          phase_d = PH_BODY;
          match_d = 3'd0;
          fill_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      match_q <= 3'd0;
      fill_q  <= '0;
      kind_q  <= KIND_NONE;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      fill_q  <= fill_d;
      kind_q  <= kind_d;
    end
  end

  a_body_waits_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !mem_busy_i)
    else $error("store written while a frame drains");

endmodule

/* design/uhfd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhfd_back
// Frame store and drain engine: replays a finished frame byte by byte, or
// emits the single overflow word of a dropped frame.
// ----------------------------------------------------------------------------
module uhfd_back #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  uhfd_pkg::wr_t   wr_i,
  input  logic            q_not_empty_i,
  input  uhfd_pkg::desc_t q_data_i,
  output logic            q_pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            out_status_o,
  output logic [1:0]      out_kind_o
);
  import uhfd_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rdata_q;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [1:0]    kind_q, kind_d;
  logic          last;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  assign busy_o       = (state_q != S_IDLE);
  assign last         = ovf_q || ((idx_q + CW'(1)) == len_q);
  assign out_valid_o  = (state_q == S_OUT);
  assign out_byte_o   = ovf_q ? 8'd0 : rdata_q;
  assign out_last_o   = last;
  assign out_status_o = ovf_q;
  assign out_kind_o   = ovf_q ? KIND_NONE : kind_q;
  assign q_pop_o      = (state_q == S_IDLE) && q_not_empty_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    kind_d  = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_not_empty_i) begin
          idx_d   = '0;
          len_d   = CW'(q_data_i.len);
          ovf_d   = q_data_i.ovf;
          kind_d  = q_data_i.kind;
          state_d = q_data_i.ovf ? S_OUT : S_RD;
        end
      end
      S_RD:  state_d = S_OUT;  // registered store read is issued here
      S_OUT: begin
        if (out_ready_i) begin
          if (last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      kind_q  <= KIND_NONE;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      kind_q  <= kind_d;
    end
  end

  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ovf_q) |-> (idx_q < len_q))
    else $error("drain index past frame end");

  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> (state_q == S_OUT))
    else $error("store read not followed by output");

endmodule

/* design/uart_header_footer_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_header_footer_deframer_core
// Finds header-delimited frames in a received byte stream, ends them on a
// two-byte footer and replays each frame with a command kind and last mark.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Contents
// s_axis    in   s_axis_tvalid/tready   tdata: rx_byte
// m_axis    out  m_axis_tvalid/tready   tdata: frame_byte; tlast: is_last;
//                                       tuser: status, command_kind
// apb       in   psel/penable/pready    0x0 header_pattern, 0x8 footer_pattern
//
// Header and body bytes are taken one per cycle while the job queue is not full.
// A frame drains word by word: S_RD does the registered store read, S_OUT
// holds the word until taken; an overflow drop gives a single word.
// Body bytes stall while a frame drains, header hunting goes on meanwhile.
// The frame store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_header_footer_deframer_core #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned HEADER_LEN   = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser,   // [0] status, [2:1] command_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import uhfd_pkg::*;

  logic [39:0] header_q;
  logic [15:0] footer_q;
  logic        cfg_wr;

  desc_t q_in, q_out;
  logic  q_push, q_pop, q_not_empty, q_not_full;
  wr_t   wr;
  logic  back_busy;
  logic  status;
  logic [1:0] kind;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? {48'd0, footer_q} : {24'd0, header_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
      footer_q <= FOOTER_RESET;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        footer_q <= pwdata[15:0];
      end else begin
        header_q <= pwdata[39:0];
      end
    end
  end

  uhfd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .HEADER_LEN  (HEADER_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .header_i    (header_q),
    .footer_i    (footer_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .mem_busy_i  (back_busy || q_not_empty),
    .q_not_full_i(q_not_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in),
    .wr_o        (wr)
  );

  uhfd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .pop_i      (q_pop),
    .pop_data_o (q_out),
    .not_empty_o(q_not_empty),
    .not_full_o (q_not_full)
  );

  uhfd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .q_not_empty_i(q_not_empty),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .busy_o       (back_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_status_o (status),
    .out_kind_o   (kind)
  );

  assign m_axis_tuser = {kind, status};

endmodule
